### sv/kmpwc_pkg.sv
// ----------------------------------------------------------------------------
// kmpwc_pkg
// Types and constants shared by the page walk checker and its port checker.
// ----------------------------------------------------------------------------
package kmpwc_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int TABLE_LEVELS      = 4;

    localparam int LVL_W      = $clog2(TABLE_LEVELS);
    localparam int IDX_W      = 9;
    localparam int FRAME_W    = 40;
    localparam int ADDR_W     = 52;
    localparam int WORD_W     = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int VA_TOP_BIT = PAGE_SHIFT + IDX_W * TABLE_LEVELS - 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [IDX_W-1:0] FIRST_TOP_RESET     = 9'd256;
    localparam logic [63:0]      KERNEL_BOUND_RESET  = 64'hFFFF_8000_0000_0000;

    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_RESP  = 1'b1;

    localparam logic [1:0] KIND_READ = 2'd0;
    localparam logic [1:0] KIND_VIOL = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic       CFG_FIRST_TOP = 1'b0;
    localparam logic       CFG_BOUNDARY  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [FRAME_W-1:0]  root_frame;
        logic [WORD_W-1:0]   entry_word;
        logic                read_failed;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          kind;
        logic [ADDR_W-1:0]   read_address;
        logic [WORD_W-1:0]   violation_address;
        logic [WORD_W-1:0]   violation_entry;
        logic                violation_large;
        logic                last;
    } t_out_word;

endpackage

### sv/kernel_mapping_page_walk_checker_unit.sv
// ----------------------------------------------------------------------------
// kernel_mapping_page_walk_checker_unit
// Depth-first four-level page table walker that flags user-accessible
// kernel mappings.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes a start word
//   carrying the root table frame, then one response word per entry read.
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns, for
//   each start or mid-walk response, an entry read address or walk-finished
//   word, optionally preceded by a violation report; last marks the final
//   word of the set. An accepted word is registered in the input register,
//   processed in a single pass and written to a 4-deep result FIFO, from
//   which results are presented. One input word per cycle is sustained
//   while results drain one per cycle and each word yields a single result;
//   a word producing two results writes both FIFO entries together. Input
//   stalls only while the FIFO has fewer than two free slots.
//   When the receiver stalls, results hold in the FIFO and the input side
//   backs up. Reset empties the FIFO, idles the walker and restores the
//   configuration registers; the per-level walk stack is not cleared.
// ----------------------------------------------------------------------------
module kernel_mapping_page_walk_checker_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  kmpwc_pkg::t_in_word    i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output kmpwc_pkg::t_out_word   o_out_word
);

    localparam int L  = kmpwc_pkg::TABLE_LEVELS;
    localparam int LW = kmpwc_pkg::LVL_W;
    localparam int IW = kmpwc_pkg::IDX_W;
    localparam int FW = kmpwc_pkg::FRAME_W;
    localparam int AW = kmpwc_pkg::ADDR_W;
    localparam int PW = kmpwc_pkg::FIFO_PTR_W;
    localparam int CW = kmpwc_pkg::FIFO_CNT_W;
    localparam int WORD_W_FIX = kmpwc_pkg::WORD_W;

    localparam logic [IW:0]   ENTRIES_C = (IW+1)'(kmpwc_pkg::ENTRIES_PER_TABLE);
    localparam logic [LW-1:0] LVL_LEAF  = LW'(L - 1);
    localparam logic [LW-1:0] LVL_DIR   = LW'(L - 2);
    localparam logic [CW-1:0] CNT_ROOM  = CW'(kmpwc_pkg::FIFO_DEPTH - 2);

    // configuration
    logic [IW-1:0]            r_first_top;
    logic [63:0]              r_kernel_bound;

    // input register
    logic                     r_in_vld;
    kmpwc_pkg::t_in_word      r_in;

    // walk state
    logic                     r_busy,  n_busy;
    logic [LW-1:0]            r_level, n_level;
    logic [FW-1:0]            r_frame [L];
    logic [FW-1:0]            n_frame [L];
    logic [IW-1:0]            r_idx   [L];
    logic [IW-1:0]            n_idx   [L];
    logic                     r_chain [L];
    logic                     n_chain [L];

    // result fifo
    kmpwc_pkg::t_out_word     r_fifo [kmpwc_pkg::FIFO_DEPTH];
    logic [PW-1:0]            r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]            r_cnt;

    logic                     in_accept;
    logic                     proc;
    logic                     out_pop;

    logic [LW-1:0]            lv;
    logic [LW-1:0]            adv_start;
    logic                     adv_found;
    logic [LW-1:0]            adv_tgt;
    logic [IW:0]              nx      [L];
    logic [IW-1:0]            adv_idx;
    logic [63:0]              leaf_va;
    logic [WORD_W_FIX-1:0]    entry;
    logic                     e_present;
    logic                     e_chain;
    logic                     is_leaf4k;
    logic                     is_leaf2m;

    kmpwc_pkg::t_out_word     res0, res1, adv_res, done_res;
    logic [1:0]               nres;

    // ------------------------------------------------------------------------
    assign in_accept  = i_in_valid && !o_in_stall;
    assign proc       = r_in_vld && (r_cnt <= CNT_ROOM);
    assign o_in_stall = r_in_vld && !proc;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_word  = r_fifo[r_rd_ptr];
    assign out_pop     = o_out_valid && !i_out_stall;

    assign lv        = (r_level >= LVL_LEAF) ? LVL_LEAF : r_level;
    assign entry     = r_in.entry_word;
    assign e_present = entry[0];
    assign e_chain   = r_chain[lv] & entry[2];
    assign is_leaf4k = (lv == LVL_LEAF);
    assign is_leaf2m = (lv == LVL_DIR) && entry[7];
    assign adv_start = r_in.read_failed ? (lv - LW'(1)) : lv;

    // level nearest the start, at or above it, that still has an entry left
    always_comb begin
        adv_found = 1'b0;
        adv_tgt   = '0;
        for (int l = 0; l < L; l++) begin
            nx[l] = {1'b0, r_idx[l]} + (IW+1)'(1);
            if ((LW'(l) <= adv_start) && (nx[l] < ENTRIES_C)) begin
                adv_found = 1'b1;
                adv_tgt   = LW'(l);
            end
        end
    end

    assign adv_idx = nx[adv_tgt][IW-1:0];

    always_comb begin
        leaf_va = '0;
        for (int i = 0; i < L; i++) begin
            if (LW'(i) <= lv) begin
                leaf_va = leaf_va | (64'(r_idx[i])
                          << (kmpwc_pkg::PAGE_SHIFT + IW * (L - 1 - i)));
            end
        end
        if (leaf_va[kmpwc_pkg::VA_TOP_BIT]) begin
            leaf_va = leaf_va | ~((64'd1 << kmpwc_pkg::VA_TOP_BIT) - 64'd1);
        end
    end

    always_comb begin
        done_res      = '0;
        done_res.kind = kmpwc_pkg::KIND_DONE;
        done_res.last = 1'b1;
        adv_res       = done_res;
        if (adv_found) begin
            adv_res.kind         = kmpwc_pkg::KIND_READ;
            adv_res.read_address = {r_frame[adv_tgt], 12'd0} + AW'({adv_idx, 3'd0});
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_frame = r_frame;
        n_idx   = r_idx;
        n_chain = r_chain;
        res0    = '0;
        res1    = '0;
        nres    = 2'd0;
        if (r_in.req_type == kmpwc_pkg::REQ_START) begin
            n_frame[0] = r_in.root_frame;
            n_chain[0] = 1'b1;
            n_level    = '0;
            n_busy     = 1'b1;
            nres       = 2'd1;
            if ({1'b0, r_first_top} < ENTRIES_C) begin
                n_idx[0]          = r_first_top;
                res0              = '0;
                res0.kind         = kmpwc_pkg::KIND_READ;
                res0.read_address = {r_in.root_frame, 12'd0}
                                    + AW'({r_first_top, 3'd0});
                res0.last         = 1'b1;
            end else begin
                n_busy = 1'b0;
                res0   = done_res;
            end
        end else if (r_busy) begin
            nres = 2'd1;
            if (r_in.read_failed && (lv == '0)) begin
                n_busy  = 1'b0;
                n_level = '0;
                res0    = done_res;
            end else if (r_in.read_failed || !e_present || is_leaf4k || is_leaf2m) begin
                if (adv_found) begin
                    n_idx[adv_tgt] = adv_idx;
                    n_level        = adv_tgt;
                end else begin
                    n_busy  = 1'b0;
                    n_level = '0;
                end
                res0 = adv_res;
                if (!r_in.read_failed && e_present && e_chain
                    && (leaf_va >= r_kernel_bound)) begin
                    res0                   = '0;
                    res0.kind              = kmpwc_pkg::KIND_VIOL;
                    res0.violation_address = leaf_va;
                    res0.violation_entry   = entry;
                    res0.violation_large   = is_leaf2m;
                    res1                   = adv_res;
                    nres                   = 2'd2;
                end
            end else begin
                n_frame[lv + LW'(1)] = entry[kmpwc_pkg::PAGE_SHIFT +: FW];
                n_idx[lv + LW'(1)]   = '0;
                n_chain[lv + LW'(1)] = e_chain;
                n_level              = lv + LW'(1);
                res0                 = '0;
                res0.kind            = kmpwc_pkg::KIND_READ;
                res0.read_address    = {entry[kmpwc_pkg::PAGE_SHIFT +: FW], 12'd0};
                res0.last            = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_top    <= kmpwc_pkg::FIRST_TOP_RESET;
            r_kernel_bound <= kmpwc_pkg::KERNEL_BOUND_RESET;
            r_in_vld       <= 1'b0;
            r_busy         <= 1'b0;
            r_level        <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kmpwc_pkg::CFG_FIRST_TOP: r_first_top    <= i_cfg_data[IW-1:0];
                    kmpwc_pkg::CFG_BOUNDARY:  r_kernel_bound <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_vld <= in_accept || (r_in_vld && !proc);
            if (proc) begin
                r_busy  <= n_busy;
                r_level <= n_level;
            end
            r_wr_ptr <= r_wr_ptr + (proc ? PW'(nres) : PW'(0));
            r_rd_ptr <= r_rd_ptr + (out_pop ? PW'(1) : PW'(0));
            r_cnt    <= r_cnt + (proc ? CW'(nres) : CW'(0)) - (out_pop ? CW'(1) : CW'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (proc) begin
            r_frame <= n_frame;
            r_idx   <= n_idx;
            r_chain <= n_chain;
            if (nres != 2'd0) begin
                r_fifo[r_wr_ptr] <= res0;
            end
            if (nres == 2'd2) begin
                r_fifo[r_wr_ptr + PW'(1)] <= res1;
            end
        end
    end

endmodule

### sv/kmpwc_checker.sv
// ----------------------------------------------------------------------------
// kmpwc_checker
// Port-level checks for the page walk checker, bound to the top level.
// ----------------------------------------------------------------------------
module kmpwc_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   o_in_stall,
    input  kmpwc_pkg::t_in_word    i_in_word,
    input  logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  kmpwc_pkg::t_out_word   o_out_word
);

    logic unused_ok;
    assign unused_ok = i_cfg_we ^ i_cfg_idx ^ (^i_cfg_data) ^ i_in_valid
                       ^ o_in_stall ^ (^i_in_word);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_viol_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.kind == kmpwc_pkg::KIND_VIOL) |-> !o_out_word.last)
        else $error("violation report marked last");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.kind == kmpwc_pkg::KIND_READ)
        |-> o_out_word.last && (o_out_word.violation_address == '0)
            && (o_out_word.violation_entry == '0) && !o_out_word.violation_large)
        else $error("read request carries violation fields");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.kind == kmpwc_pkg::KIND_DONE)
        |-> o_out_word.last && (o_out_word.read_address == '0))
        else $error("malformed walk-finished word");

    a_viol_then_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_out_word.kind == kmpwc_pkg::KIND_VIOL)
        |=> o_out_valid && (o_out_word.kind != kmpwc_pkg::KIND_VIOL))
        else $error("violation report not followed by its closing word");

endmodule

bind kernel_mapping_page_walk_checker_unit kmpwc_checker u_kmpwc_checker (.*);

### bench/walk_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// walk_result_checker
// Watches both channels and the register port of the page walk checker,
// keeps its own copy of the walk stack and registers, works out the result
// words of every accepted input word and compares them in order with the
// words the block returns.
// ----------------------------------------------------------------------------
module walk_result_checker
    import kmpwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    output int          o_results_due,
    output int          o_fail_count
);

    localparam int REPORT_MAX = 50;

    logic [IDX_W-1:0]   top_first;
    logic [WORD_W-1:0]  kern_bound;
    logic               walking;
    int                 cur_level;
    logic [FRAME_W-1:0] tbl_frame [TABLE_LEVELS];
    logic [IDX_W-1:0]   tbl_index [TABLE_LEVELS];
    logic               user_ok   [TABLE_LEVELS];

    t_out_word          results_due [$];
    t_out_word          held_word;
    logic               held_valid;

    initial begin
        o_results_due = 0;
        o_fail_count  = 0;
    end

    // the newest word is held back so that the final one can get its last flag
    function automatic void queue_result(input logic [1:0] kind,
                                         input logic [ADDR_W-1:0] ra,
                                         input logic [WORD_W-1:0] va,
                                         input logic [WORD_W-1:0] ent,
                                         input logic lg);
        if (held_valid)
            results_due.push_back(held_word);
        held_word = '{kind: kind, read_address: ra, violation_address: va,
                      violation_entry: ent, violation_large: lg, last: 1'b0};
        held_valid = 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] entry_address(input int lv);
        return {tbl_frame[lv], tbl_index[lv], 3'b000};
    endfunction

    function automatic void end_walk();
        walking   = 1'b0;
        cur_level = 0;
        queue_result(KIND_DONE, '0, '0, '0, 1'b0);
    endfunction

    // step to the next entry, popping exhausted tables
    function automatic void next_entry(input int lv);
        int   l;
        int   nx;
        logic done;
        l    = lv;
        done = 1'b0;
        while (!done) begin
            nx = int'(tbl_index[l]) + 1;
            if (nx < ENTRIES_PER_TABLE) begin
                tbl_index[l] = IDX_W'(nx);
                cur_level    = l;
                queue_result(KIND_READ, entry_address(l), '0, '0, 1'b0);
                done = 1'b1;
            end else if (l == 0) begin
                end_walk();
                done = 1'b1;
            end else begin
                l--;
            end
        end
    endfunction

    function automatic logic [WORD_W-1:0] leaf_vaddr(input int lv);
        logic [WORD_W-1:0] va;
        va = '0;
        for (int i = 0; i <= lv; i++)
            va |= WORD_W'(tbl_index[i]) << (PAGE_SHIFT + IDX_W * (TABLE_LEVELS - 1 - i));
        if (va[VA_TOP_BIT])
            va[WORD_W-1:VA_TOP_BIT] = '1;
        return va;
    endfunction

    function automatic void step_walker(input t_in_word w);
        int                lv;
        logic [WORD_W-1:0] e;
        logic [WORD_W-1:0] va;
        logic              chain;
        logic              leaf4k;
        logic              leaf2m;
        held_valid = 1'b0;
        if (w.req_type == REQ_START) begin
            tbl_frame[0] = w.root_frame;
            user_ok[0]   = 1'b1;
            cur_level    = 0;
            walking      = 1'b1;
            if (int'(top_first) < ENTRIES_PER_TABLE) begin
                tbl_index[0] = top_first;
                queue_result(KIND_READ, entry_address(0), '0, '0, 1'b0);
            end else begin
                end_walk();
            end
        end else if (walking) begin
            lv = cur_level;
            e  = w.entry_word;
            if (w.read_failed) begin
                if (lv == 0)
                    end_walk();
                else
                    next_entry(lv - 1);
            end else if (!e[0]) begin
                next_entry(lv);
            end else begin
                chain  = user_ok[lv] & e[2];
                leaf4k = (lv == TABLE_LEVELS - 1);
                leaf2m = (lv == TABLE_LEVELS - 2) && e[7];
                if (leaf4k || leaf2m) begin
                    va = leaf_vaddr(lv);
                    if (chain && va >= kern_bound)
                        queue_result(KIND_VIOL, '0, va, e, leaf2m);
                    next_entry(lv);
                end else begin
                    tbl_frame[lv+1] = e[PAGE_SHIFT +: FRAME_W];
                    tbl_index[lv+1] = '0;
                    user_ok[lv+1]   = chain;
                    cur_level       = lv + 1;
                    queue_result(KIND_READ, entry_address(lv + 1), '0, '0, 1'b0);
                end
            end
        end
        if (held_valid) begin
            held_word.last = 1'b1;
            results_due.push_back(held_word);
        end
    endfunction

    function automatic string word_text(input t_out_word w);
        return $sformatf("kind=%0d ra=%h va=%h ent=%h large=%b last=%b",
                         w.kind, w.read_address, w.violation_address,
                         w.violation_entry, w.violation_large, w.last);
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            top_first  = FIRST_TOP_RESET;
            kern_bound = KERNEL_BOUND_RESET;
            walking    = 1'b0;
            cur_level  = 0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIRST_TOP)
                    top_first = i_cfg_data[IDX_W-1:0];
                else
                    kern_bound = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    if (o_fail_count < REPORT_MAX)
                        $display("%0t: unexpected word: expected none, got %s",
                                 $time, word_text(i_out_word));
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_word !== want) begin
                        if (o_fail_count < REPORT_MAX)
                            $display("%0t: mismatch: expected %s, got %s",
                                     $time, word_text(want), word_text(i_out_word));
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                step_walker(i_in_word);
        end
        o_results_due <= results_due.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the page walk checker with directed walks (violations at both page
// sizes, failed reads, exhausted tables, restarts, ignored responses) and
// then random walks under several register settings, with random idling on
// both sides and one long receiver hold-off; the checker scores the results.
// ----------------------------------------------------------------------------
module tb;
    import kmpwc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_idx   = 1'b0;
    logic [63:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    int          results_due;
    int          fail_count;
    int          cycle_cnt = 0;
    logic        quiet     = 1'b0;
    logic        hold_req  = 1'b0;

    kernel_mapping_page_walk_checker_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    walk_result_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .o_results_due (results_due),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: short random stall bursts, one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left == 0) begin
                if (hold_req) begin
                    hold_req   = 1'b0;
                    stall_left = HOLD_CYCLES;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 6);
                end
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] make_entry(input logic present, input logic user,
                                               input logic big_page);
        logic [63:0] e;
        e    = rand64();
        e[0] = present;
        e[2] = user;
        e[7] = big_page;
        return e;
    endfunction

    function automatic t_in_word start_word(input logic [FRAME_W-1:0] root);
        t_in_word w;
        w.req_type    = REQ_START;
        w.root_frame  = root;
        w.entry_word  = rand64();
        w.read_failed = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic t_in_word resp_word(input logic [63:0] e, input logic failed);
        t_in_word w;
        w.req_type    = REQ_RESP;
        w.root_frame  = FRAME_W'(rand64());
        w.entry_word  = e;
        w.read_failed = failed;
        return w;
    endfunction

    function automatic t_in_word random_resp();
        int       pick;
        t_in_word w;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return resp_word(make_entry(1'b1, $urandom_range(0, 7) != 0, 1'b0), 1'b0);
        if (pick < 55)
            return resp_word(make_entry(1'b1, $urandom_range(0, 7) != 0, 1'b1), 1'b0);
        if (pick < 80)
            return resp_word(make_entry(1'b0, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))), 1'b0);
        if (pick < 90)
            return resp_word(rand64(), 1'b1);
        // noise: any word at all, starts included
        w.req_type    = 1'($urandom_range(0, 1));
        w.root_frame  = FRAME_W'(rand64());
        w.entry_word  = rand64();
        w.read_failed = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_walks(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            send_word(start_word(FRAME_W'(rand64())));
            len = $urandom_range(4, 30);
            repeat (len) send_word(random_resp());
            sent += len + 1;
        end
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: first top index 256, boundary at the kernel half
        send_word(start_word('1));
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b0), 1'b0));
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b1), 1'b0));   // 1 GiB descends
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b0), 1'b0));
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b0), 1'b0));   // 4K violation
        send_word(resp_word(make_entry(1'b0, 1'b1, 1'b1), 1'b0));
        send_word(resp_word(make_entry(1'b1, 1'b0, 1'b0), 1'b0));   // supervisor leaf
        send_word(resp_word(rand64(), 1'b1));                       // skip the table
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b1), 1'b0));   // 2M violation
        send_word(resp_word(make_entry(1'b1, 1'b0, 1'b0), 1'b0));   // chain broken
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b0), 1'b0));
        send_word(start_word('0));                                  // restart while busy
        send_word(resp_word('1, 1'b0));
        send_word(resp_word('0, 1'b0));
        send_word(resp_word(rand64(), 1'b1));
        send_word(resp_word(rand64(), 1'b1));                       // top fails: done
        send_word(resp_word('1, 1'b1));                             // idle: ignored
        settle();

        // last top entry only, every leaf counts as kernel
        write_reg(CFG_FIRST_TOP, 64'(511));
        write_reg(CFG_BOUNDARY, '0);
        send_word(start_word(FRAME_W'(rand64())));
        send_word(resp_word(make_entry(1'b0, 1'b1, 1'b0), 1'b0));   // top exhausted
        send_word(start_word(FRAME_W'(rand64())));
        send_word(resp_word(rand64(), 1'b1));
        send_word(start_word(FRAME_W'(rand64())));
        send_word(resp_word(make_entry(1'b1, 1'b1, 1'b0), 1'b0));
        repeat (ENTRIES_PER_TABLE)                                  // pop past the top
            send_word(resp_word(make_entry(1'b0, 1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1))), 1'b0));
        settle();

        write_reg(CFG_FIRST_TOP, '0);
        write_reg(CFG_BOUNDARY, '1);
        run_walks(150);
        settle();

        write_reg(CFG_FIRST_TOP, 64'($urandom_range(0, 511)));
        write_reg(CFG_BOUNDARY, rand64());
        hold_req = 1'b1;
        run_walks(250);
        settle();

        write_reg(CFG_FIRST_TOP, 64'(FIRST_TOP_RESET));
        write_reg(CFG_BOUNDARY, KERNEL_BOUND_RESET);
        run_walks(200);
        settle();

        quiet = 1'b1;
        write_reg(CFG_FIRST_TOP, 64'($urandom_range(256, 511)));
        write_reg(CFG_BOUNDARY, '0);
        run_walks(170);
        settle();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
